// ===== rtl/hbp_pkg.sv =====
`default_nettype none

package hbp_pkg;

    // default sizes of the code table
    localparam int SYMBOL_COUNT_DEF  = 256;
    localparam int MAX_CODE_BITS_DEF = 64;

    // fixed field widths
    localparam int BYTE_BITS      = 8;
    localparam int SYMBOL_BITS    = 8;
    localparam int CODE_WORD_BITS = 64;
    localparam int LENGTH_BITS    = 7;
    localparam int REQ_BITS       = 2;

    // stream widths: tdata carries symbol, code_word, code_length, padded to bytes
    localparam int IN_FIELD_BITS = SYMBOL_BITS + CODE_WORD_BITS + LENGTH_BITS;
    localparam int IN_TDATA_BITS = ((IN_FIELD_BITS + BYTE_BITS - 1) / BYTE_BITS) * BYTE_BITS;
    localparam int OUT_TDATA_BITS = BYTE_BITS;

    // request codes carried in tuser
    localparam logic [REQ_BITS-1:0] REQ_LOAD   = 2'd0;
    localparam logic [REQ_BITS-1:0] REQ_ENCODE = 2'd1;
    localparam logic [REQ_BITS-1:0] REQ_FLUSH  = 2'd2;

    // control from the packer to the code table
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } tbl_ctl_t;

    // packer sequencer states
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_READ  = 4'b0010,
        ST_PACK  = 4'b0100,
        ST_FLUSH = 4'b1000
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/hbp_code_table.sv =====
`default_nettype none

module hbp_code_table #(
    parameter int SYMBOL_COUNT  = hbp_pkg::SYMBOL_COUNT_DEF,
    parameter int MAX_CODE_BITS = hbp_pkg::MAX_CODE_BITS_DEF
) (
    input  wire                                   clk,
    input  hbp_pkg::tbl_ctl_t                     ctl,
    input  wire  [$clog2(SYMBOL_COUNT)-1:0]       idx,
    input  wire  [MAX_CODE_BITS-1:0]              wr_code,
    input  wire  [$clog2(MAX_CODE_BITS+1)-1:0]    wr_len,
    output logic [MAX_CODE_BITS-1:0]              rd_code,
    output logic [$clog2(MAX_CODE_BITS+1)-1:0]    rd_len
);
    import hbp_pkg::*;

    localparam int LEN_W = $clog2(MAX_CODE_BITS + 1);

    logic [MAX_CODE_BITS-1:0] code_mem [SYMBOL_COUNT];
    logic [LEN_W-1:0]         len_mem  [SYMBOL_COUNT];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            code_mem[idx] <= wr_code;
            len_mem[idx]  <= wr_len;
        end
        if (ctl.rd_en)
        begin
            rd_code <= code_mem[idx];
            rd_len  <= len_mem[idx];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/huffman_code_bit_packer_core.sv =====
`default_nettype none
// Huffman code bit packer.
// Input stream (s_axis): one item per request. tuser holds the request kind:
// load a table entry, encode a symbol, or flush the partial byte. Loads write
// the code table. An encode reads the table through the registered read port,
// loads the shift register, then moves up to eight code bits per cycle into
// the partial byte while the receiver does not stall; a zero-length code
// moves no bits. A flush with bits pending gives one byte from the flush
// state once the output register is free; an empty flush gives nothing.
// Output stream (m_axis): one completed byte per item, first bit in bit 7;
// tlast marks the final byte that a request produces.
// The input is taken only while the sequencer is idle. A byte waiting in the
// output register does not block loads or the start of an encode; packing
// pauses only when a further byte completes while the receiver stalls.
// Reset clears the partial byte, its fill count and the output valid flag; the
// code table is not cleared and each entry must be loaded before it is used.

module huffman_code_bit_packer_core #(
    parameter int SYMBOL_COUNT  = hbp_pkg::SYMBOL_COUNT_DEF,
    parameter int MAX_CODE_BITS = hbp_pkg::MAX_CODE_BITS_DEF
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   s_axis_tvalid,
    output logic                                  s_axis_tready,
    // symbol [7:0], code_word [71:8], code_length [78:72], zero [79]
    input  wire  [hbp_pkg::IN_TDATA_BITS-1:0]     s_axis_tdata,
    // req_type [1:0]
    input  wire  [hbp_pkg::REQ_BITS-1:0]          s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire                                   m_axis_tready,
    // out_byte [7:0]
    output logic [hbp_pkg::OUT_TDATA_BITS-1:0]    m_axis_tdata,
    output logic                                  m_axis_tlast
);
    import hbp_pkg::*;

    localparam int IDX_W = $clog2(SYMBOL_COUNT);
    localparam int LEN_W = $clog2(MAX_CODE_BITS + 1);
    localparam int CNT_W = $clog2(BYTE_BITS + 1);
    localparam int FILL_W = $clog2(BYTE_BITS);
    localparam logic [LENGTH_BITS-1:0] MAX_LEN_IN = LENGTH_BITS'(MAX_CODE_BITS);
    localparam logic [SYMBOL_BITS:0]   SYM_LIMIT  = (SYMBOL_BITS + 1)'(SYMBOL_COUNT);

    // input fields
    logic [SYMBOL_BITS-1:0]    in_symbol;
    logic [CODE_WORD_BITS-1:0] in_code;
    logic [LENGTH_BITS-1:0]    in_len;
    logic                      in_accept;
    logic                      in_range;
    logic [IDX_W-1:0]          tbl_idx;
    logic [LEN_W-1:0]          len_sat;

    assign in_symbol = s_axis_tdata[SYMBOL_BITS-1:0];
    assign in_code   = s_axis_tdata[SYMBOL_BITS +: CODE_WORD_BITS];
    assign in_len    = s_axis_tdata[SYMBOL_BITS + CODE_WORD_BITS +: LENGTH_BITS];
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign in_range  = {1'b0, in_symbol} < SYM_LIMIT;
    assign tbl_idx   = in_symbol[IDX_W-1:0];
    assign len_sat   = (in_len > MAX_LEN_IN) ? LEN_W'(MAX_CODE_BITS) : LEN_W'(in_len);

    // state
    state_t                   state_reg, state_next;
    logic [MAX_CODE_BITS-1:0] shift_reg, shift_next;
    logic [LEN_W-1:0]         rem_reg, rem_next;
    logic [BYTE_BITS-1:0]     partial_reg, partial_next;
    logic [FILL_W-1:0]        fill_reg, fill_next;
    logic                     out_valid_reg, out_valid_next;
    logic [BYTE_BITS-1:0]     out_byte_reg, out_byte_next;
    logic                     out_last_reg, out_last_next;

    // table
    tbl_ctl_t                 tbl_ctl;
    logic [MAX_CODE_BITS-1:0] rd_code;
    logic [LEN_W-1:0]         rd_len;

    hbp_code_table #(
        .SYMBOL_COUNT  (SYMBOL_COUNT),
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_hbp_code_table (
        .clk     (clk),
        .ctl     (tbl_ctl),
        .idx     (tbl_idx),
        .wr_code (in_code[CODE_WORD_BITS-1 -: MAX_CODE_BITS]),
        .wr_len  (len_sat),
        .rd_code (rd_code),
        .rd_len  (rd_len)
    );

    // one packing step: merge up to a byte's room of code bits
    logic [CNT_W-1:0]     room;
    logic [CNT_W-1:0]     take;
    logic [BYTE_BITS-1:0] top_bits;
    logic [BYTE_BITS-1:0] merged;
    logic [CNT_W-1:0]     fill_sum;
    logic [LEN_W-1:0]     rem_after;
    logic                 completes;
    logic                 can_load;

    assign room      = CNT_W'(BYTE_BITS) - CNT_W'(fill_reg);
    assign take      = (rem_reg < LEN_W'(room)) ? CNT_W'(rem_reg) : room;
    assign top_bits  = shift_reg[MAX_CODE_BITS-1 -: BYTE_BITS]
                       & ~({BYTE_BITS{1'b1}} >> take);
    assign merged    = partial_reg | (top_bits >> fill_reg);
    assign fill_sum  = CNT_W'(fill_reg) + take;
    assign completes = (fill_sum == CNT_W'(BYTE_BITS));
    assign rem_after = rem_reg - LEN_W'(take);
    assign can_load  = !out_valid_reg || m_axis_tready;

    assign s_axis_tready = (state_reg == ST_IDLE);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        shift_next     = shift_reg;
        rem_next       = rem_reg;
        partial_next   = partial_reg;
        fill_next      = fill_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        tbl_ctl        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    priority if (s_axis_tuser == REQ_LOAD)
                    begin
                        tbl_ctl.wr_en = in_range;
                    end
                    else if (s_axis_tuser == REQ_ENCODE)
                    begin
                        tbl_ctl.rd_en = in_range;
                        if (in_range)
                            state_next = ST_READ;
                    end
                    else if (s_axis_tuser == REQ_FLUSH)
                    begin
                        if (fill_reg != '0)
                            state_next = ST_FLUSH;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_READ:
            begin
                shift_next = rd_code;
                rem_next   = rd_len;
                state_next = (rd_len == '0) ? ST_IDLE : ST_PACK;
            end
            ST_PACK:
            begin
                if (!completes || can_load)
                begin
                    shift_next = shift_reg << take;
                    rem_next   = rem_after;
                    if (completes)
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = merged;
                        out_last_next  = (rem_after < LEN_W'(BYTE_BITS));
                        partial_next   = '0;
                        fill_next      = '0;
                    end
                    else
                    begin
                        partial_next = merged;
                        fill_next    = fill_sum[FILL_W-1:0];
                    end
                    if (rem_after == '0)
                        state_next = ST_IDLE;
                end
            end
            ST_FLUSH:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = partial_reg;
                    out_last_next  = 1'b1;
                    partial_next   = '0;
                    fill_next      = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            partial_reg   <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            partial_reg   <= partial_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        shift_reg    <= shift_next;
        rem_reg      <= rem_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ===== rtl/hbp_checker.sv =====
`default_nettype none

module hbp_checker #(
    parameter int SYMBOL_COUNT = hbp_pkg::SYMBOL_COUNT_DEF
) (
    input wire                                clk,
    input wire                                rst_n,
    input wire                                s_axis_tvalid,
    input wire                                s_axis_tready,
    input wire [hbp_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,
    input wire [hbp_pkg::REQ_BITS-1:0]        s_axis_tuser,
    input wire                                m_axis_tvalid,
    input wire                                m_axis_tready,
    input wire [hbp_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata,
    input wire                                m_axis_tlast
);
    import hbp_pkg::*;

    localparam logic [SYMBOL_BITS:0] SYM_LIMIT = (SYMBOL_BITS + 1)'(SYMBOL_COUNT);

    logic in_accept;
    logic sym_ok;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign sym_ok    = {1'b0, s_axis_tdata[SYMBOL_BITS-1:0]} < SYM_LIMIT;

    // a stalled output item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output item changed while stalled");

    // an encode of a table symbol occupies the sequencer
    a_encode_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && s_axis_tuser == REQ_ENCODE && sym_ok |=> !s_axis_tready)
        else $error("input taken right after an encode");

    // a load leaves the input ready in the following cycle
    a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && s_axis_tuser == REQ_LOAD |=> s_axis_tready)
        else $error("not ready after a load");

    // no output item appears in the cycle after an input is taken
    a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !$rose(m_axis_tvalid))
        else $error("output item appeared too early");

endmodule

bind huffman_code_bit_packer_core hbp_checker #(
    .SYMBOL_COUNT (SYMBOL_COUNT)
) u_hbp_checker (.*);

`default_nettype wire

// ===== verif/packer_check_pkg.sv =====
`timescale 1ns / 1ps

package packer_check_pkg;

    import hbp_pkg::*;

    // request kind that the packer ignores
    localparam logic [REQ_BITS-1:0] REQ_UNUSED = 2'd3;

    // one packed byte as it should leave the block
    typedef struct packed {
        logic [BYTE_BITS-1:0] out_byte;
        logic                 last;
    } packed_byte_t;

    class packed_byte_tracker;

        logic [CODE_WORD_BITS-1:0] code_table [SYMBOL_COUNT_DEF];
        logic [LENGTH_BITS-1:0]    length_table [SYMBOL_COUNT_DEF];
        logic [BYTE_BITS-1:0]      partial;
        int                        fill;
        packed_byte_t              pending_bytes [$];
        int                        errors;

        function new();
            partial = '0;
            fill    = 0;
            errors  = 0;
        endfunction

        // clears code bits past the code length
        function logic [CODE_WORD_BITS-1:0] keep_mask(logic [LENGTH_BITS-1:0] len);
            if (len == 0)
                return '0;
            return ~64'd0 << (CODE_WORD_BITS - len);
        endfunction

        // advance the packer state for one accepted item, queue its bytes
        function void note_request(logic [REQ_BITS-1:0] req, logic [SYMBOL_BITS-1:0] sym,
                                   logic [CODE_WORD_BITS-1:0] word,
                                   logic [LENGTH_BITS-1:0] len);
            logic [LENGTH_BITS-1:0]    eff_len;
            logic [CODE_WORD_BITS-1:0] code;
            int                        start_count;
            packed_byte_t              tail;
            start_count = pending_bytes.size();
            case (req)
                REQ_LOAD:
                begin
                    // overlong lengths saturate
                    eff_len = len;
                    if (eff_len > MAX_CODE_BITS_DEF)
                        eff_len = 7'd64;
                    code_table[sym]   = word & keep_mask(eff_len);
                    length_table[sym] = eff_len;
                end
                REQ_ENCODE:
                begin
                    code = code_table[sym];
                    for (int k = 0; k < length_table[sym]; k++)
                    begin
                        partial[7 - fill] = code[63 - k];
                        fill++;
                        if (fill == BYTE_BITS)
                        begin
                            pending_bytes.push_back('{out_byte: partial, last: 1'b0});
                            partial = '0;
                            fill    = 0;
                        end
                    end
                    // mark the final byte of this request
                    if (pending_bytes.size() > start_count)
                    begin
                        tail      = pending_bytes.pop_back();
                        tail.last = 1'b1;
                        pending_bytes.push_back(tail);
                    end
                end
                REQ_FLUSH:
                begin
                    // an empty partial byte gives nothing
                    if (fill != 0)
                    begin
                        pending_bytes.push_back('{out_byte: partial, last: 1'b1});
                        partial = '0;
                        fill    = 0;
                    end
                end
                default:
                begin
                end
            endcase
        endfunction

        // compare one output item with the oldest queued byte
        function void check_byte(logic [BYTE_BITS-1:0] data, logic last);
            packed_byte_t want;
            if (pending_bytes.size() == 0)
            begin
                $error("unexpected item: out_byte %h last %b", data, last);
                errors++;
                return;
            end
            want = pending_bytes.pop_front();
            if (data !== want.out_byte)
            begin
                $error("out_byte expected %h actual %h", want.out_byte, data);
                errors++;
            end
            if (last !== want.last)
            begin
                $error("last expected %b actual %b", want.last, last);
                errors++;
            end
        endfunction

    endclass

endpackage

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    import hbp_pkg::*;
    import packer_check_pkg::*;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      s_valid = 1'b0;
    logic [IN_TDATA_BITS-1:0]  s_data = '0;
    logic [REQ_BITS-1:0]       s_user = REQ_LOAD;
    logic                      m_ready = 1'b0;
    wire                       s_axis_tready;
    wire                       m_axis_tvalid;
    wire [OUT_TDATA_BITS-1:0]  m_axis_tdata;
    wire                       m_axis_tlast;

    int                        send_idle_pct = 0;
    int                        recv_stall_pct = 0;
    bit                        table_loaded [SYMBOL_COUNT_DEF];
    logic [SYMBOL_BITS-1:0]    loaded_syms [$];

    packed_byte_tracker tracker = new();

    huffman_code_bit_packer_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_user),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    always #5 clk = ~clk;

    // input monitor: update the prediction on every accepted item
    always @(posedge clk)
    begin
        if (s_valid && s_axis_tready)
            tracker.note_request(s_user, s_data[7:0], s_data[71:8], s_data[78:72]);
    end

    // output side: check accepted items, stall at random
    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_ready)
            tracker.check_byte(m_axis_tdata, m_axis_tlast);
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // present one item and hold it until accepted
    task automatic send_item(input logic [REQ_BITS-1:0] req, input logic [SYMBOL_BITS-1:0] sym,
                             input logic [CODE_WORD_BITS-1:0] word,
                             input logic [LENGTH_BITS-1:0] len);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_valid <= 1'b0;
            @(posedge clk);
        end
        s_valid <= 1'b1;
        s_user  <= req;
        s_data  <= {1'b0, len, word, sym};
        if (req == REQ_LOAD && !table_loaded[sym])
        begin
            table_loaded[sym] = 1'b1;
            loaded_syms.push_back(sym);
        end
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // stop sending until every queued byte has come out
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending_bytes.size() != 0)
            @(posedge clk);
    endtask

    // one random request; unused kinds do not count
    task automatic send_random(output bit counted);
        logic [REQ_BITS-1:0]       req;
        logic [SYMBOL_BITS-1:0]    sym;
        logic [CODE_WORD_BITS-1:0] word;
        logic [LENGTH_BITS-1:0]    len;
        int                        pick;
        pick    = int'($urandom_range(99));
        sym     = SYMBOL_BITS'($urandom_range(255));
        word    = {$urandom, $urandom};
        counted = 1'b1;
        // mostly short codes, some long, some empty, a few anywhere in the field
        case ($urandom_range(9))
            7:       len = LENGTH_BITS'($urandom_range(13, 64));
            8:       len = LENGTH_BITS'($urandom_range(0, 127));
            9:       len = 7'd0;
            default: len = LENGTH_BITS'($urandom_range(1, 12));
        endcase
        if (pick < 22)
            req = REQ_LOAD;
        else if (pick < 80)
        begin
            req = REQ_ENCODE;
            sym = loaded_syms[$urandom_range(loaded_syms.size() - 1)];
        end
        else if (pick < 93)
            req = REQ_FLUSH;
        else
        begin
            req     = REQ_UNUSED;
            counted = 1'b0;
        end
        send_item(req, sym, word, len);
    endtask

    // stimulus
    initial
    begin
        int count;
        bit counted;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: table extremes, stray bits, saturation, flush cases
        send_item(REQ_LOAD, 8'd0, {$urandom, $urandom}, 7'd0);
        send_item(REQ_LOAD, 8'd255, ~64'd0, 7'd64);
        send_item(REQ_LOAD, 8'd1, 64'h8000_0000_0000_0000, 7'd1);
        send_item(REQ_LOAD, 8'd2, {$urandom, $urandom}, 7'd127);
        send_item(REQ_LOAD, 8'd3, ~64'd0, 7'd7);
        send_item(REQ_LOAD, 8'd4, 64'hA5FF_FFFF_FFFF_FFFF, 7'd8);
        send_item(REQ_ENCODE, 8'd0, ~64'd0, 7'd127);
        send_item(REQ_ENCODE, 8'd4, 64'd0, 7'd0);
        send_item(REQ_ENCODE, 8'd1, 64'd0, 7'd0);
        send_item(REQ_FLUSH, 8'd0, 64'd0, 7'd0);
        send_item(REQ_FLUSH, 8'd255, ~64'd0, 7'd127);
        send_item(REQ_ENCODE, 8'd255, 64'd0, 7'd0);
        send_item(REQ_ENCODE, 8'd3, 64'd0, 7'd0);
        send_item(REQ_ENCODE, 8'd2, 64'd0, 7'd0);
        send_item(REQ_UNUSED, 8'd255, ~64'd0, 7'd127);
        send_item(REQ_ENCODE, 8'd255, 64'd0, 7'd0);
        send_item(REQ_FLUSH, 8'd0, 64'd0, 7'd0);
        send_item(REQ_LOAD, 8'd128, 64'd0, 7'd65);
        send_item(REQ_ENCODE, 8'd128, 64'd0, 7'd0);
        send_item(REQ_LOAD, 8'd5, 64'h0123_4567_89AB_CDEF, 7'd64);
        send_item(REQ_ENCODE, 8'd5, 64'd0, 7'd0);
        send_item(REQ_FLUSH, 8'd0, 64'd0, 7'd0);
        drain_results();

        // random phases with different idle and stall rates
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 60;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 60;
                end
                default:
                begin
                    send_idle_pct  = 12;
                    recv_stall_pct = 12;
                end
            endcase
            count = 0;
            while (count < 50)
            begin
                send_random(counted);
                if (counted)
                    count++;
                // hold off mid-phase until the output side catches up
                if (count == 25 && ph == 2)
                    drain_results();
            end
            drain_results();
        end

        // let any late item show up
        repeat (30) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending_bytes.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/hbp_pkg.sv
rtl/hbp_code_table.sv
rtl/huffman_code_bit_packer_core.sv
rtl/hbp_checker.sv
verif/packer_check_pkg.sv
verif/testbench.sv
